[src/tlca_pkg.sv]
package tlca_pkg;

  localparam int NODE_W      = 10;
  localparam int TABLE_DEPTH = 1 << NODE_W;
  localparam int MAX_NODES   = 1024;
  localparam int STEP_W      = $clog2(MAX_NODES + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);
  localparam logic [NODE_W-1:0] NO_NODE   = NODE_W'(0);

  localparam logic REQ_SET    = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [1:0] {
    OP_SET,
    OP_QUERY,
    OP_FAIL
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CLIMB_A,
    ST_CLIMB_B,
    ST_LIFT,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e               op;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

[src/tlca_ifs.sv]
interface tlca_req_if
  import tlca_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [NODE_W-1:0] node;
  logic [NODE_W-1:0] other_node;

  modport source (output valid, output req_type, output node, output other_node,
                  input ready);
  modport sink (input valid, input req_type, input node, input other_node,
                output ready);
endinterface

interface tlca_rsp_if
  import tlca_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] ancestor;
  logic              status;

  modport source (output valid, output ancestor, output status, input ready);
  modport sink (input valid, input ancestor, input status, output ready);
endinterface

[src/tlca_front.sv]
module tlca_front
  import tlca_pkg::*;
(
  tlca_req_if.sink req_i,
  input  logic       full_i,
  input  back_stat_t stat_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  logic accept;

  assign req_i.ready = !full_i && !stat_i.clearing;
  assign accept      = req_i.valid && req_i.ready;

  // a set on node zero changes nothing, so it is dropped here
  always_comb begin
    cmd_o.a = req_i.node;
    cmd_o.b = req_i.other_node;
    if (req_i.req_type == REQ_SET) begin
      cmd_o.op = OP_SET;
      push_o   = accept && (req_i.node != NO_NODE);
    end else begin
      // a query naming node zero fails without a climb
      cmd_o.op = ((req_i.node == NO_NODE) || (req_i.other_node == NO_NODE)) ?
                 OP_FAIL : OP_QUERY;
      push_o   = accept;
    end
  end

endmodule

[src/tlca_fifo.sv]
module tlca_fifo
  import tlca_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  input  logic pop_i,
  output cmd_t pop_data_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t              q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o    = (cnt_q == QCNT_W'(0));
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? QPTR_W'(0) : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? QPTR_W'(0) : rd_ptr_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[src/tlca_back.sv]
module tlca_back
  import tlca_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  cmd_t       cmd_i,
  output logic       pop_o,
  output back_stat_t stat_o,
  tlca_rsp_if.source rsp_o
);

  logic [NODE_W-1:0] parent_mem [TABLE_DEPTH];

  state_e            state_q, state_d;
  logic [NODE_W-1:0] clr_q, clr_d;
  logic [NODE_W-1:0] x_q, x_d;
  logic [NODE_W-1:0] a_q, a_d;
  logic [NODE_W-1:0] b_q, b_d;
  logic [STEP_W-1:0] steps_q, steps_d;
  logic [STEP_W-1:0] da_q, da_d;
  logic [STEP_W-1:0] db_q, db_d;
  logic [NODE_W-1:0] res_anc_q, res_anc_d;
  logic              res_err_q, res_err_d;
  logic              out_valid_q, out_valid_d;
  logic [NODE_W-1:0] out_anc_q;
  logic              out_err_q;
  logic              out_load;

  logic              we;
  logic [NODE_W-1:0] waddr, wdata;
  logic [NODE_W-1:0] raddr0, raddr1;
  logic [NODE_W-1:0] rd0_q, rd1_q;
  logic              slot_free;

  assign slot_free = !out_valid_q || rsp_o.ready;

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    x_d       = x_q;
    a_d       = a_q;
    b_d       = b_q;
    steps_d   = steps_q;
    da_d      = da_q;
    db_d      = db_q;
    res_anc_d = res_anc_q;
    res_err_d = res_err_q;
    pop_o     = 1'b0;
    we        = 1'b0;
    waddr     = clr_q;
    wdata     = NO_NODE;
    out_load  = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        clr_d = clr_q + NODE_W'(1);
        if (clr_q == NODE_W'(TABLE_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          unique case (cmd_i.op)
            OP_SET: begin
              we    = 1'b1;
              waddr = cmd_i.a;
              wdata = cmd_i.b;
            end
            OP_QUERY: begin
              a_d     = cmd_i.a;
              b_d     = cmd_i.b;
              x_d     = cmd_i.a;
              steps_d = '0;
              state_d = ST_CLIMB_A;
            end
            default: begin
              res_anc_d = NO_NODE;
              res_err_d = STATUS_ERR;
              state_d   = ST_DONE;
            end
          endcase
        end
      end
      ST_CLIMB_A, ST_CLIMB_B: begin
        // rd0_q holds the parent of the cursor
        priority if (x_q == ROOT_NODE) begin
          steps_d = '0;
          if (state_q == ST_CLIMB_A) begin
            da_d    = steps_q;
            x_d     = b_q;
            state_d = ST_CLIMB_B;
          end else begin
            db_d    = steps_q;
            state_d = ST_LIFT;
          end
        end else if ((x_q == NO_NODE) || (steps_q >= STEP_W'(MAX_NODES))) begin
          res_anc_d = NO_NODE;
          res_err_d = STATUS_ERR;
          state_d   = ST_DONE;
        end else begin
          x_d     = rd0_q;
          steps_d = steps_q + STEP_W'(1);
        end
      end
      ST_LIFT: begin
        // rd0_q and rd1_q hold the parents of a and b
        priority if (a_q == b_q) begin
          res_anc_d = a_q;
          res_err_d = STATUS_OK;
          state_d   = ST_DONE;
        end else if (da_q > db_q) begin
          a_d  = rd0_q;
          da_d = da_q - STEP_W'(1);
        end else begin
          b_d  = rd1_q;
          db_d = (db_q != '0) ? db_q - STEP_W'(1) : db_q;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // the read address follows the cursor that the next cycle will look at
  assign raddr0 = ((state_d == ST_CLIMB_A) || (state_d == ST_CLIMB_B)) ? x_d : a_d;
  assign raddr1 = b_d;

  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    a_q       <= a_d;
    b_q       <= b_d;
    steps_q   <= steps_d;
    da_q      <= da_d;
    db_q      <= db_d;
    res_anc_q <= res_anc_d;
    res_err_q <= res_err_d;
    if (out_load) begin
      out_anc_q <= res_anc_q;
      out_err_q <= res_err_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      parent_mem[waddr] <= wdata;
    end
    rd0_q <= parent_mem[raddr0];
    rd1_q <= parent_mem[raddr1];
  end

  assign stat_o.clearing = (state_q == ST_CLEAR);

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.ancestor = out_anc_q;
  assign rsp_o.status   = out_err_q;

endmodule

[src/tree_lowest_common_ancestor_core.sv]
// channel  dir  payload                          request taken when
// req_i    in   req_type, node, other_node        req_i.valid && req_i.ready
// rsp_o    out  ancestor, status                  rsp_o.valid && rsp_o.ready
//
// a set_parent request is written as it is dequeued; queries are worked one at a time
// a query is dequeued, climbs from a and then from b to the root (one parent table read
// per level), lifts the deeper node (b on a tie) until the two meet, and loads the output
// register; a failing query stops early; after reset a clearing pass zeroes the 1024 entry
// parent table with req_i held not ready; a four entry queue lets requests arrive while the
// back end climbs
// a result waits in the output register while rsp_o stalls, the back end holds its next one

module tree_lowest_common_ancestor_core
  import tlca_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  tlca_req_if.sink   req_i,
  tlca_rsp_if.source rsp_o
);

  logic       push;
  cmd_t       push_cmd;
  logic       pop;
  cmd_t       pop_cmd;
  logic       full;
  logic       empty;
  back_stat_t stat;

  // front end: handshake and sorting of requests into set, query and failed query
  tlca_front u_front (
    .req_i  (req_i),
    .full_i (full),
    .stat_i (stat),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  // short queue between the two halves
  tlca_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd),
    .full_o      (full),
    .empty_o     (empty)
  );

  // back end: parent table, climb and lift sequencer, output register
  tlca_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .cmd_i   (pop_cmd),
    .pop_o   (pop),
    .stat_o  (stat),
    .rsp_o   (rsp_o)
  );

  // no request taken while the table is being cleared
  a_clear_blocks_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> !req_i.ready)
    else $error("request accepted during clearing pass");

  // no result can exist before the table is cleared
  a_clear_no_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> !rsp_o.valid)
    else $error("result shown during clearing pass");

  // the clearing pass never restarts once finished
  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stat.clearing |=> !stat.clearing)
    else $error("clearing pass restarted");

endmodule
